// ===== design/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} core_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_SLOT = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		case (r)
			6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== design/sha256_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source(output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface
`default_nettype wire

// ===== design/sha256_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== design/sha256_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha256_front
	import sha256_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sha256_in_if.sink   data_in,
	output qhead_t      head,
	input  wire logic   pop
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       push;
	logic       take;

	// Items with neither a byte nor an end mark change nothing and are dropped here.
	assign data_in.ready = (cnt_q != 2'd2);
	assign accept = data_in.valid && data_in.ready;
	assign push = accept && (data_in.byte_present || data_in.end_of_message);
	assign take = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{data_byte: data_in.data_byte,
				byte_present: data_in.byte_present,
				end_of_message: data_in.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, take};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> (cnt_q == 2'd0))
		else $error("queue count changed while empty");

endmodule
`default_nettype wire

// ===== design/sha256_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha256_core
	import sha256_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  qhead_t     head,
	output logic       pop,
	sha256_out_if.source digest_out
);

	core_state_t st_q, st_d, ret_q, follow;
	logic [31:0] hash_q [8];
	logic [31:0] win_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [63:0] total_q;
	logic [63:0] len_q;
	logic [2:0]  len_cnt_q;
	logic [23:0] word_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        ov_q;
	logic [31:0] od_q;
	logic [2:0]  oi_q;
	logic        ol_q;

	logic        absorb;
	logic [7:0]  abyte;
	logic        cap_len;
	logic        out_load;
	logic        restart;
	logic [31:0] new_word;
	logic [31:0] w_next;
	logic [31:0] t1, t2;
	logic [5:0]  pos_next;

	assign pos_next = total_q[5:0] + 6'd1;
	assign new_word = {word_q, abyte};
	assign w_next = (rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10))
		+ win_q[9]
		+ (rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3))
		+ win_q[0];
	assign t1 = h_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + round_k(round_q) + win_q[0];
	assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	always_comb begin
		st_d = st_q;
		follow = st_q;
		absorb = 1'b0;
		abyte = 8'd0;
		cap_len = 1'b0;
		out_load = 1'b0;
		restart = 1'b0;
		pop = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.byte_present) begin
						absorb = 1'b1;
						abyte = head.item.data_byte;
						follow = head.item.end_of_message ? ST_PAD80 : ST_IDLE;
					end else begin
						st_d = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				absorb = 1'b1;
				abyte = PAD_MARK;
				cap_len = 1'b1;
				follow = (pos_next == LEN_SLOT) ? ST_LEN : ST_ZERO;
			end
			ST_ZERO: begin
				absorb = 1'b1;
				follow = (pos_next == LEN_SLOT) ? ST_LEN : ST_ZERO;
			end
			ST_LEN: begin
				absorb = 1'b1;
				abyte = len_q[63:56];
				follow = (len_cnt_q == 3'd7) ? ST_OUT : ST_LEN;
			end
			ST_ROUND: begin
				if (round_q == 6'd63) st_d = ST_ADD;
			end
			ST_ADD: begin
				st_d = ret_q;
			end
			ST_OUT: begin
				if (!ov_q || digest_out.ready) begin
					out_load = 1'b1;
					if (idx_q == 3'd7) begin
						restart = 1'b1;
						st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (absorb) st_d = (total_q[5:0] == 6'd63) ? ST_ROUND : follow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			total_q <= '0;
			round_q <= '0;
			len_cnt_q <= '0;
			idx_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else begin
			st_q <= st_d;
			if (absorb) begin
				ret_q <= follow;
				total_q <= total_q + 64'd1;
			end
			if (absorb && total_q[5:0] == 6'd63) round_q <= '0;
			else if (st_q == ST_ROUND) round_q <= round_q + 6'd1;
			if (cap_len) len_cnt_q <= '0;
			else if (st_q == ST_LEN) len_cnt_q <= len_cnt_q + 3'd1;
			if (st_q == ST_ADD) begin
				hash_q[0] <= hash_q[0] + a_q;
				hash_q[1] <= hash_q[1] + b_q;
				hash_q[2] <= hash_q[2] + c_q;
				hash_q[3] <= hash_q[3] + d_q;
				hash_q[4] <= hash_q[4] + e_q;
				hash_q[5] <= hash_q[5] + f_q;
				hash_q[6] <= hash_q[6] + g_q;
				hash_q[7] <= hash_q[7] + h_q;
			end
			if (out_load) begin
				ov_q <= 1'b1;
				idx_q <= idx_q + 3'd1;
			end else if (digest_out.ready) begin
				ov_q <= 1'b0;
			end
			if (restart) begin
				total_q <= '0;
				for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap_len) len_q <= {total_q[60:0], 3'b000};
		else if (st_q == ST_LEN) len_q <= {len_q[55:0], 8'd0};
		if (absorb) begin
			word_q <= new_word[23:0];
			if (total_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
				win_q[15] <= new_word;
			end
			if (total_q[5:0] == 6'd63) begin
				a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
				e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
			end
		end
		if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= w_next;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
		if (out_load) begin
			od_q <= hash_q[idx_q];
			oi_q <= idx_q;
			ol_q <= (idx_q == 3'd7);
		end
	end

	assign digest_out.valid = ov_q;
	assign digest_out.digest_word = od_q;
	assign digest_out.word_index = oi_q;
	assign digest_out.last_word = ol_q;

	a_round_only: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != 6'd0) |-> (st_q == ST_ROUND || st_q == ST_ADD && round_q == 6'd0))
		else $error("round counter running outside compression");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && round_q == 6'd63) |=> (st_q == ST_ADD))
		else $error("compression did not end after the last round");
	a_add_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ADD) |-> (total_q[5:0] == 6'd0))
		else $error("block finished with a partial block count");
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && idx_q == 3'd7) |=> (st_q == ST_IDLE && total_q == 64'd0))
		else $error("message state not restarted after the last word");

endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel     Role    Payload
// data_in     sink    data_byte, byte_present, end_of_message
// digest_out  source  digest_word, word_index, last_word
//
// The engine absorbs queued bytes while idle; each full 64-byte block is then
// compressed by 64 rounds of the single round unit plus the hash update.
// A message end adds 9 to 72 padding bytes, one or two blocks, and 8 output words;
// the output stalls for as long as digest_out holds a word without ready.
// A two-item queue lets input be taken while the engine compresses or outputs.
// Reset loads the initial hash and clears the length; no clearing pass is needed.
module sha256_stream_hasher_unit
	import sha256_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha256_in_if.sink    data_in,
	sha256_out_if.source digest_out
);

	qhead_t head;
	logic   pop;

	sha256_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_in (data_in),
		.head    (head),
		.pop     (pop)
	);

	sha256_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.digest_out (digest_out)
	);

endmodule
`default_nettype wire
